/* sv/jsu_pkg.sv */
// Package for the JSON string unescape block: phase codes, character codes,
// result kinds, error codes, the state and result-bundle types and helper functions.
// No dependencies.
package jsu_pkg;

    // Decoder phases
    localparam logic [3:0] PH_IDLE   = 4'd0;
    localparam logic [3:0] PH_BODY   = 4'd1;
    localparam logic [3:0] PH_ESC    = 4'd2;
    localparam logic [3:0] PH_HEX    = 4'd3;
    localparam logic [3:0] PH_HIWAIT = 4'd4;
    localparam logic [3:0] PH_HIESC  = 4'd5;
    localparam logic [3:0] PH_LOWHEX = 4'd6;
    localparam logic [3:0] PH_DONE   = 4'd7;
    localparam logic [3:0] PH_DROP   = 4'd8;

    // Result kinds
    localparam logic [1:0] KIND_DATA  = 2'd0;
    localparam logic [1:0] KIND_CLOSE = 2'd1;
    localparam logic [1:0] KIND_ERROR = 2'd2;

    // Error codes
    localparam logic [2:0] ERR_NONE     = 3'd0;
    localparam logic [2:0] ERR_NO_QUOTE = 3'd1;
    localparam logic [2:0] ERR_ESCAPE   = 3'd2;
    localparam logic [2:0] ERR_HEX      = 3'd3;
    localparam logic [2:0] ERR_UNTERM   = 3'd4;

    // Characters
    localparam logic [7:0] CH_QUOTE = 8'h22;
    localparam logic [7:0] CH_BSL   = 8'h5C;
    localparam logic [7:0] CH_SLASH = 8'h2F;
    localparam logic [7:0] CH_B     = 8'h62;
    localparam logic [7:0] CH_F     = 8'h66;
    localparam logic [7:0] CH_N     = 8'h6E;
    localparam logic [7:0] CH_R     = 8'h72;
    localparam logic [7:0] CH_T     = 8'h74;
    localparam logic [7:0] CH_U     = 8'h75;

    localparam logic [15:0] SURR_HI_MIN = 16'hD800;
    localparam logic [15:0] SURR_HI_MAX = 16'hDBFF;
    localparam logic [31:0] SURR_LO_BASE = 32'h0000DC00;
    localparam logic [31:0] SUPP_BASE   = 32'h00010000;

    typedef struct packed {
        logic [3:0]  phase;
        logic [9:0]  high_half;   // low ten bits of a held high surrogate
        logic [15:0] hex_accum;
        logic [1:0]  digit_count;
    } state_t;

    // All results of one input item: UTF-8 bytes, one single byte, one terminal
    typedef struct packed {
        logic [3:0][7:0] ubytes;
        logic [2:0]      ulen;
        logic            sb_en;
        logic [7:0]      sb;
        logic            term_en;
        logic [1:0]      term_kind;
        logic [2:0]      err;
    } bundle_t;

    // Effect of a body or escape byte
    typedef struct packed {
        logic [3:0] phase;
        logic       sb_en;
        logic [7:0] sb;
        logic       term_en;
        logic [1:0] term_kind;
        logic [2:0] err;
    } act_t;

    // {valid, value}
    function automatic logic [4:0] hex_val(input logic [7:0] b);
        logic [4:0] r;
        begin
            r = 5'd0;
            if (b >= 8'h30 && b <= 8'h39) begin
                r = {1'b1, 4'(b - 8'h30)};
            end else if (b >= 8'h61 && b <= 8'h66) begin
                r = {1'b1, 4'(b - 8'h57)};
            end else if (b >= 8'h41 && b <= 8'h46) begin
                r = {1'b1, 4'(b - 8'h37)};
            end
            return r;
        end
    endfunction

    function automatic act_t body_act(input logic [7:0] b);
        act_t a;
        begin
            a = '0;
            a.phase = PH_BODY;
            if (b == CH_QUOTE) begin
                a.term_en   = 1'b1;
                a.term_kind = KIND_CLOSE;
                a.phase     = PH_DONE;
            end else if (b == CH_BSL) begin
                a.phase = PH_ESC;
            end else begin
                a.sb_en = 1'b1;
                a.sb    = b;
            end
            return a;
        end
    endfunction

    function automatic act_t esc_act(input logic [7:0] b);
        act_t a;
        begin
            a = '0;
            a.phase = PH_BODY;
            a.sb_en = 1'b1;
            unique case (b)
                CH_QUOTE: a.sb = CH_QUOTE;
                CH_BSL:   a.sb = CH_BSL;
                CH_SLASH: a.sb = CH_SLASH;
                CH_B:     a.sb = 8'h08;
                CH_F:     a.sb = 8'h0C;
                CH_N:     a.sb = 8'h0A;
                CH_R:     a.sb = 8'h0D;
                CH_T:     a.sb = 8'h09;
                CH_U: begin
                    a.sb_en = 1'b0;
                    a.phase = PH_HEX;
                end
                default: begin
                    a.sb_en     = 1'b0;
                    a.term_en   = 1'b1;
                    a.term_kind = KIND_ERROR;
                    a.err       = ERR_ESCAPE;
                    a.phase     = PH_DROP;
                end
            endcase
            return a;
        end
    endfunction

    // Surrogate pair join, modulo 2^32; the low half is not checked
    function automatic logic [31:0] joined(input logic [9:0] hh, input logic [15:0] acc);
        begin
            return SUPP_BASE + {12'h000, hh, 10'h000} + ({16'h0000, acc} - SURR_LO_BASE);
        end
    endfunction

endpackage

/* sv/jsu_decode.sv */
// Next-state and result-bundle logic for one text byte.
// Depends on jsu_pkg.
module jsu_decode import jsu_pkg::*; (
    input  state_t      cur,
    input  logic [7:0]  text_byte,
    input  logic        end_of_text,
    output state_t      nxt,
    output bundle_t     bundle,
    output logic [2:0]  res_count
);

    logic [3:0]  ph;
    logic [9:0]  hh;
    logic [15:0] acc;
    logic [15:0] acc_shift;
    logic [1:0]  dc;
    logic [31:0] cp;
    logic        cp_en;
    logic [4:0]  hx;
    act_t        act;
    logic        sb_en;
    logic [7:0]  sb;
    logic        term_en;
    logic [1:0]  term_kind;
    logic [2:0]  err;

    assign hx        = hex_val(text_byte);
    assign acc_shift = {cur.hex_accum[11:0], hx[3:0]};

    always_comb begin
        ph        = cur.phase;
        hh        = cur.high_half;
        acc       = cur.hex_accum;
        dc        = cur.digit_count;
        cp        = 32'd0;
        cp_en     = 1'b0;
        sb_en     = 1'b0;
        sb        = 8'd0;
        term_en   = 1'b0;
        term_kind = KIND_DATA;
        err       = ERR_NONE;
        act       = '0;

        unique case (cur.phase) inside
            PH_IDLE: begin
                if (text_byte == CH_QUOTE) begin
                    ph = PH_BODY;
                end else begin
                    term_en   = 1'b1;
                    term_kind = KIND_ERROR;
                    err       = ERR_NO_QUOTE;
                    ph        = PH_DROP;
                end
            end
            PH_BODY: begin
                act = body_act(text_byte);
            end
            PH_ESC: begin
                act = esc_act(text_byte);
            end
            PH_HEX, PH_LOWHEX: begin
                if (!hx[4]) begin
                    term_en   = 1'b1;
                    term_kind = KIND_ERROR;
                    err       = ERR_HEX;
                    ph        = PH_DROP;
                end else begin
                    acc = acc_shift;
                    if (cur.digit_count == 2'd3) begin
                        dc = 2'd0;
                        if (cur.phase == PH_LOWHEX) begin
                            cp    = joined(cur.high_half, acc_shift);
                            cp_en = 1'b1;
                            ph    = PH_BODY;
                        end else if (acc_shift >= SURR_HI_MIN && acc_shift <= SURR_HI_MAX) begin
                            hh = acc_shift[9:0];
                            ph = PH_HIWAIT;
                        end else begin
                            cp    = {16'h0000, acc_shift};
                            cp_en = 1'b1;
                            ph    = PH_BODY;
                        end
                    end else begin
                        dc = cur.digit_count + 2'd1;
                    end
                end
            end
            PH_HIWAIT: begin
                if (text_byte == CH_BSL) begin
                    ph = PH_HIESC;
                end else begin
                    cp    = {16'h0000, 6'b110110, cur.high_half};
                    cp_en = 1'b1;
                    act   = body_act(text_byte);
                end
            end
            PH_HIESC: begin
                if (text_byte == CH_U) begin
                    ph  = PH_LOWHEX;
                    acc = 16'd0;
                    dc  = 2'd0;
                end else begin
                    cp    = {16'h0000, 6'b110110, cur.high_half};
                    cp_en = 1'b1;
                    act   = esc_act(text_byte);
                end
            end
            default: begin
            end
        endcase

        // Apply a body or escape action where one was taken
        if (cur.phase == PH_BODY || cur.phase == PH_ESC ||
            (cur.phase == PH_HIWAIT && text_byte != CH_BSL) ||
            (cur.phase == PH_HIESC && text_byte != CH_U)) begin
            ph        = act.phase;
            sb_en     = act.sb_en;
            sb        = act.sb;
            term_en   = act.term_en;
            term_kind = act.term_kind;
            err       = act.err;
            if (act.phase == PH_HEX) begin
                acc = 16'd0;
                dc  = 2'd0;
            end
        end

        // End of text: flush pending work, flag an open string, return to idle
        if (end_of_text) begin
            unique case (ph) inside
                PH_HEX: begin
                    cp    = {16'h0000, acc};
                    cp_en = 1'b1;
                end
                PH_LOWHEX: begin
                    cp    = joined(hh, acc);
                    cp_en = 1'b1;
                end
                PH_HIWAIT, PH_HIESC: begin
                    cp    = {16'h0000, 6'b110110, hh};
                    cp_en = 1'b1;
                end
                default: begin
                end
            endcase
            if (ph == PH_HEX || ph == PH_LOWHEX || ph == PH_HIWAIT ||
                ph == PH_HIESC || ph == PH_BODY || ph == PH_ESC) begin
                term_en   = 1'b1;
                term_kind = KIND_ERROR;
                err       = ERR_UNTERM;
            end
            ph  = PH_IDLE;
            hh  = 10'd0;
            acc = 16'd0;
            dc  = 2'd0;
        end
    end

    // UTF-8 encoding by code point size; leading bytes cut to 8 bits
    always_comb begin
        bundle.ubytes    = '0;
        bundle.ulen      = 3'd0;
        bundle.sb_en     = sb_en;
        bundle.sb        = sb;
        bundle.term_en   = term_en;
        bundle.term_kind = term_kind;
        bundle.err       = err;
        if (cp_en) begin
            if (cp[31:7] == 25'd0) begin
                bundle.ubytes[0] = cp[7:0];
                bundle.ulen      = 3'd1;
            end else if (cp[31:11] == 21'd0) begin
                bundle.ubytes[0] = 8'hC0 | cp[13:6];
                bundle.ubytes[1] = {2'b10, cp[5:0]};
                bundle.ulen      = 3'd2;
            end else if (cp[31:16] == 16'd0) begin
                bundle.ubytes[0] = 8'hE0 | cp[19:12];
                bundle.ubytes[1] = {2'b10, cp[11:6]};
                bundle.ubytes[2] = {2'b10, cp[5:0]};
                bundle.ulen      = 3'd3;
            end else begin
                bundle.ubytes[0] = 8'hF0 | cp[25:18];
                bundle.ubytes[1] = {2'b10, cp[17:12]};
                bundle.ubytes[2] = {2'b10, cp[11:6]};
                bundle.ubytes[3] = {2'b10, cp[5:0]};
                bundle.ulen      = 3'd4;
            end
        end
    end

    assign res_count = bundle.ulen + {2'b00, sb_en} + {2'b00, term_en};

    assign nxt.phase       = ph;
    assign nxt.high_half   = hh;
    assign nxt.hex_accum   = acc;
    assign nxt.digit_count = dc;

endmodule

/* sv/jsu_outq.sv */
// Two-slot result-bundle queue that drains one result per transfer.
// Depends on jsu_pkg.
module jsu_outq import jsu_pkg::*; (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        push,
    input  bundle_t     push_bundle,
    input  logic [2:0]  push_count,
    output logic        has_room,
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata,
    output logic [1:0]  m_tuser,
    output logic        m_tlast
);

    bundle_t    slot_reg [2];
    logic [2:0] total_reg [2];
    logic       wr_ptr_reg;
    logic       rd_ptr_reg;
    logic [1:0] count_reg;
    logic [1:0] count_next;
    logic [2:0] idx_reg;
    logic [2:0] idx_next;
    bundle_t    head;
    logic [2:0] head_total;
    logic       pop;
    logic       take;

    assign head       = slot_reg[rd_ptr_reg];
    assign head_total = total_reg[rd_ptr_reg];
    assign has_room   = (count_reg != 2'd2);
    assign m_tvalid   = (count_reg != 2'd0);
    assign take       = m_tvalid && m_tready;
    assign m_tlast    = (idx_reg == head_total - 3'd1);
    assign pop        = take && m_tlast;

    always_comb begin
        m_tdata = 16'd0;
        m_tuser = KIND_DATA;
        if (idx_reg < head.ulen) begin
            m_tdata[7:0] = head.ubytes[idx_reg[1:0]];
        end else if (idx_reg == head.ulen && head.sb_en) begin
            m_tdata[7:0] = head.sb;
        end else begin
            m_tuser = head.term_kind;
            if (head.term_kind == KIND_ERROR) begin
                m_tdata[10:8] = head.err;
            end
        end
    end

    always_comb begin
        count_next = count_reg + {1'b0, push} - {1'b0, pop};
        idx_next   = idx_reg;
        if (pop) begin
            idx_next = 3'd0;
        end else if (take) begin
            idx_next = idx_reg + 3'd1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
            idx_reg    <= 3'd0;
        end else begin
            count_reg <= count_next;
            idx_reg   <= idx_next;
            if (push) begin
                wr_ptr_reg <= ~wr_ptr_reg;
            end
            if (pop) begin
                rd_ptr_reg <= ~rd_ptr_reg;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            slot_reg[wr_ptr_reg]  <= push_bundle;
            total_reg[wr_ptr_reg] <= push_count;
        end
    end

endmodule

/* sv/json_string_unescape_utf8.sv */
// Top level of the JSON string unescape block: decoder state registers,
// byte decoder and result queue. Depends on jsu_pkg, jsu_decode and jsu_outq.
//
// Decodes the body of one JSON string per text and writes raw bytes. Each text
// must start with a double quote; plain bytes pass through, simple escapes become
// their characters and \uXXXX becomes UTF-8 of one to four bytes (a high surrogate
// followed by \u joins the next four digits unchecked; a lone surrogate gives three
// bytes). The closing quote gives a close marker; the first error gives an error
// marker and drops input until the byte flagged by s_tlast, which always returns
// the block to waiting for a quote. One input transfer is taken per cycle while
// the two-slot result queue has a free slot; each byte is decoded in the cycle it
// is taken and gives zero to five results, which leave one per cycle on the m_
// side while m_tready is high, so the sustained rate is one byte per cycle
// whenever bytes give at most one result each, and otherwise is bounded by the
// number of results per byte. There is no memory and no clearing pass after reset.
module json_string_unescape_utf8 import jsu_pkg::*; (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] text_byte
    input  logic        s_tlast,   // end_of_text
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata,   // [7:0] out_byte, [10:8] error_code, rest zero
    output logic [1:0]  m_tuser,   // [1:0] kind
    output logic        m_tlast    // last_of_run
);

    state_t     state_reg;
    state_t     state_next;
    bundle_t    bundle;
    logic [2:0] res_count;
    logic       has_room;
    logic       accept;

    assign s_tready = has_room;
    assign accept   = s_tvalid && s_tready;

    jsu_decode u_decode (
        .cur         (state_reg),
        .text_byte   (s_tdata),
        .end_of_text (s_tlast),
        .nxt         (state_next),
        .bundle      (bundle),
        .res_count   (res_count)
    );

    // Advance decoder state on every accepted transfer
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= '0;
        end else if (accept) begin
            state_reg <= state_next;
        end
    end

    // Queue only items that produce results; the rest just move the state
    jsu_outq u_outq (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .push        (accept && (res_count != 3'd0)),
        .push_bundle (bundle),
        .push_count  (res_count),
        .has_room    (has_room),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tuser     (m_tuser),
        .m_tlast     (m_tlast)
    );

endmodule

/* test/json_string_unescape_utf8_test.sv */
// Testbench for json_string_unescape_utf8: streams JSON string texts in, predicts the
// decoded bytes, close and error markers, and checks every output transfer in order.
// Depends on jsu_pkg and the json_string_unescape_utf8 RTL.
module json_string_unescape_utf8_test;
    import jsu_pkg::*;

    // One expected output transfer
    typedef struct packed {
        logic [7:0] data;
        logic [1:0] kind;
        logic [2:0] err;
        logic       tail;
    } result_t;

    // Decoder state, decoded-result predictor and ordered result checker
    class unescape_scoreboard;
        logic [3:0]  dec_phase;
        logic [15:0] held_high;
        logic [15:0] digit_acc;
        logic [1:0]  digits_taken;
        result_t     step_results[$];
        result_t     awaited[$];
        int          mismatches;
        int          total_bytes;
        int          live_bytes;
        int          seen_results;
        int          closes;
        int          faults;

        function new();
            restart();
            mismatches   = 0;
            total_bytes  = 0;
            live_bytes   = 0;
            seen_results = 0;
            closes       = 0;
            faults       = 0;
        endfunction

        function void restart();
            dec_phase    = PH_IDLE;
            held_high    = '0;
            digit_acc    = '0;
            digits_taken = '0;
        endfunction

        function void push_result(logic [7:0] d, logic [1:0] k, logic [2:0] e);
            result_t r;
            r.data = d;
            r.kind = k;
            r.err  = e;
            r.tail = 1'b0;
            step_results = {step_results, r};
        endfunction

        function void raise(logic [2:0] code);
            push_result(8'h00, KIND_ERROR, code);
            dec_phase = PH_DROP;
        endfunction

        // Size the UTF-8 sequence by code point; lead bytes keep only 8 bits
        function void emit_utf8_bytes(logic [31:0] cp);
            if (cp < 32'h80) begin
                push_result(cp[7:0], KIND_DATA, ERR_NONE);
            end else if (cp < 32'h800) begin
                push_result(8'hC0 | cp[13:6], KIND_DATA, ERR_NONE);
                push_result({2'b10, cp[5:0]}, KIND_DATA, ERR_NONE);
            end else if (cp < 32'h10000) begin
                push_result(8'hE0 | cp[19:12], KIND_DATA, ERR_NONE);
                push_result({2'b10, cp[11:6]}, KIND_DATA, ERR_NONE);
                push_result({2'b10, cp[5:0]}, KIND_DATA, ERR_NONE);
            end else begin
                push_result(8'hF0 | cp[25:18], KIND_DATA, ERR_NONE);
                push_result({2'b10, cp[17:12]}, KIND_DATA, ERR_NONE);
                push_result({2'b10, cp[11:6]}, KIND_DATA, ERR_NONE);
                push_result({2'b10, cp[5:0]}, KIND_DATA, ERR_NONE);
            end
        endfunction

        // Low half is taken as is, so the sum may wrap
        function logic [31:0] pair_code_point();
            logic [31:0] hi_off;
            logic [31:0] lo_off;
            hi_off = {16'h0000, held_high} - {16'h0000, SURR_HI_MIN};
            lo_off = {16'h0000, digit_acc} - SURR_LO_BASE;
            return SUPP_BASE + (hi_off << 10) + lo_off;
        endfunction

        function int hex_nibble(logic [7:0] b);
            if (b >= "0" && b <= "9") return int'(b - "0");
            if (b >= "a" && b <= "f") return int'(b - "a") + 10;
            if (b >= "A" && b <= "F") return int'(b - "A") + 10;
            return -1;
        endfunction

        function void body_char(logic [7:0] b);
            if (b == CH_QUOTE) begin
                push_result(8'h00, KIND_CLOSE, ERR_NONE);
                dec_phase = PH_DONE;
            end else if (b == CH_BSL) begin
                dec_phase = PH_ESC;
            end else begin
                push_result(b, KIND_DATA, ERR_NONE);
            end
        endfunction

        function void escape_char(logic [7:0] b);
            logic [7:0] ch;
            logic       plain;
            plain = 1'b1;
            ch    = b;
            case (b) inside
                CH_QUOTE, CH_BSL, CH_SLASH: ch = b;
                CH_B: ch = 8'h08;
                CH_F: ch = 8'h0C;
                CH_N: ch = 8'h0A;
                CH_R: ch = 8'h0D;
                CH_T: ch = 8'h09;
                CH_U: begin
                    plain        = 1'b0;
                    dec_phase    = PH_HEX;
                    digit_acc    = '0;
                    digits_taken = '0;
                end
                default: begin
                    plain = 1'b0;
                    raise(ERR_ESCAPE);
                end
            endcase
            if (plain) begin
                push_result(ch, KIND_DATA, ERR_NONE);
                dec_phase = PH_BODY;
            end
        endfunction

        // Returns 1 once the fourth digit of a group is in
        function bit hex_char(logic [7:0] b);
            int v;
            v = hex_nibble(b);
            if (v < 0) begin
                raise(ERR_HEX);
                return 1'b0;
            end
            digit_acc = {digit_acc[11:0], v[3:0]};
            if (digits_taken == 2'd3) begin
                digits_taken = '0;
                return 1'b1;
            end
            digits_taken = digits_taken + 2'd1;
            return 1'b0;
        endfunction

        // Note one accepted input transfer and queue the results it causes
        function void take_text_byte(logic [7:0] b, logic eot);
            result_t r;
            step_results.delete();
            total_bytes++;
            if (dec_phase != PH_DONE && dec_phase != PH_DROP) live_bytes++;
            case (dec_phase)
                PH_IDLE: begin
                    if (b == CH_QUOTE) dec_phase = PH_BODY;
                    else raise(ERR_NO_QUOTE);
                end
                PH_BODY: body_char(b);
                PH_ESC:  escape_char(b);
                PH_HEX: begin
                    if (hex_char(b)) begin
                        if (digit_acc >= SURR_HI_MIN && digit_acc <= SURR_HI_MAX) begin
                            held_high = digit_acc;
                            dec_phase = PH_HIWAIT;
                        end else begin
                            emit_utf8_bytes({16'h0000, digit_acc});
                            dec_phase = PH_BODY;
                        end
                    end
                end
                PH_HIWAIT: begin
                    if (b == CH_BSL) begin
                        dec_phase = PH_HIESC;
                    end else begin
                        emit_utf8_bytes({16'h0000, held_high});
                        dec_phase = PH_BODY;
                        body_char(b);
                    end
                end
                PH_HIESC: begin
                    if (b == CH_U) begin
                        dec_phase    = PH_LOWHEX;
                        digit_acc    = '0;
                        digits_taken = '0;
                    end else begin
                        emit_utf8_bytes({16'h0000, held_high});
                        escape_char(b);
                    end
                end
                PH_LOWHEX: begin
                    if (hex_char(b)) begin
                        emit_utf8_bytes(pair_code_point());
                        dec_phase = PH_BODY;
                    end
                end
                default: ;
            endcase

            // End of text: flush whatever is pending, flag unterminated, go idle
            if (eot) begin
                case (dec_phase) inside
                    PH_HEX: begin
                        emit_utf8_bytes({16'h0000, digit_acc});
                        raise(ERR_UNTERM);
                    end
                    PH_LOWHEX: begin
                        emit_utf8_bytes(pair_code_point());
                        raise(ERR_UNTERM);
                    end
                    PH_HIWAIT, PH_HIESC: begin
                        emit_utf8_bytes({16'h0000, held_high});
                        raise(ERR_UNTERM);
                    end
                    PH_BODY, PH_ESC: raise(ERR_UNTERM);
                    default: ;
                endcase
                restart();
            end

            if (step_results.size() > 0) begin
                r = step_results.pop_back();
                r.tail = 1'b1;
                step_results = {step_results, r};
            end
            awaited = {awaited, step_results};
        endfunction

        task report(string what);
            $display("MISMATCH @%0t: %s", $time, what);
            mismatches++;
        endtask

        // Compare one output transfer against the oldest expectation
        task check_result(logic [15:0] tdata, logic [1:0] tuser, logic tlast);
            result_t want;
            seen_results++;
            if (awaited.size() == 0) begin
                report($sformatf("unexpected result byte=%h err=%0d kind=%0d last=%0b",
                                 tdata[7:0], tdata[10:8], tuser, tlast));
                return;
            end
            want = awaited.pop_front();
            if (want.kind == KIND_CLOSE) closes++;
            if (want.kind == KIND_ERROR) faults++;
            if (tdata[7:0] !== want.data || tdata[10:8] !== want.err ||
                tuser !== want.kind || tlast !== want.tail) begin
                report($sformatf("got byte=%h err=%0d kind=%0d last=%0b, want %h/%0d/%0d/%0b",
                                 tdata[7:0], tdata[10:8], tuser, tlast,
                                 want.data, want.err, want.kind, want.tail));
            end
        endtask
    endclass

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [7:0]  s_tdata = 8'h00;    // [7:0] text_byte
    logic        s_tlast = 1'b0;     // end_of_text
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [15:0] m_tdata;            // [7:0] out_byte, [10:8] error_code, rest zero
    logic [1:0]  m_tuser;            // [1:0] kind
    logic        m_tlast;            // last_of_run

    int unsigned src_idle_pct = 0;
    int unsigned sink_idle_pct = 0;
    int          texts_sent = 0;
    logic [7:0]  text_q[$];

    unescape_scoreboard board = new();

    json_string_unescape_utf8 dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    initial begin
        forever #5 aclk = ~aclk;
    end

    // Receiver: decide back-pressure at the falling edge, take transfers at the rising edge
    always @(negedge aclk) begin
        m_tready = ($urandom_range(99) >= sink_idle_pct);
    end

    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) board.check_result(m_tdata, m_tuser, m_tlast);
    end

    // Offer one byte, with random idle cycles first, and hold it until the transfer
    task automatic send_byte(logic [7:0] b, logic eot);
        @(negedge aclk);
        while ($urandom_range(99) < src_idle_pct) begin
            s_tvalid = 1'b0;
            @(negedge aclk);
        end
        s_tvalid = 1'b1;
        s_tdata  = b;
        s_tlast  = eot;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        board.take_text_byte(b, eot);
    endtask

    // Send the built text with end_of_text on its final byte, then clear it
    task automatic send_text();
        foreach (text_q[i]) send_byte(text_q[i], i == text_q.size() - 1);
        texts_sent++;
        text_q.delete();
    endtask

    // Append one byte to the text being built
    function automatic void append_char(logic [7:0] b);
        text_q = {text_q, b};
    endfunction

    function automatic void add_chars(string s);
        for (int i = 0; i < s.len(); i++) append_char(s[i]);
    endfunction

    function automatic logic [7:0] hex_ascii(logic [3:0] n);
        if (n < 4'd10) return "0" + {4'h0, n};
        return ($urandom_range(1) ? "A" : "a") + {4'h0, n} - 8'd10;
    endfunction

    function automatic void add_u_escape(logic [15:0] code);
        append_char(CH_BSL);
        append_char(CH_U);
        for (int i = 3; i >= 0; i--) append_char(hex_ascii(code[i*4 +: 4]));
    endfunction

    // One body element: plain byte, simple escape or \u group of some size class
    function automatic void add_element();
        logic [7:0]  b;
        logic [7:0]  escapes[8];
        logic [15:0] lo;
        escapes = '{CH_QUOTE, CH_BSL, CH_SLASH, CH_B, CH_F, CH_N, CH_R, CH_T};
        case ($urandom_range(15)) inside
            [0:5]: begin
                b = 8'($urandom_range(255));
                if (b == CH_QUOTE || b == CH_BSL) b = b ^ 8'h01;
                append_char(b);
            end
            [6:8]: begin
                append_char(CH_BSL);
                append_char(escapes[3'($urandom_range(7))]);
            end
            9:  add_u_escape(16'($urandom_range(16'h007F)));
            10: add_u_escape(16'($urandom_range(16'h07FF, 16'h0080)));
            11: add_u_escape(16'($urandom_range(16'hFFFF, 16'h0800)));
            12, 13: begin
                // pair; the low half is usually in range, sometimes anything
                add_u_escape(16'($urandom_range(16'hDBFF, 16'hD800)));
                if ($urandom_range(3) == 0) lo = 16'($urandom_range(16'hFFFF));
                else lo = 16'($urandom_range(16'hDFFF, 16'hDC00));
                add_u_escape(lo);
            end
            14: add_u_escape(16'($urandom_range(16'hDBFF, 16'hD800)));
            default: begin
                case ($urandom_range(2))
                    0: add_u_escape(16'h0000);
                    1: add_u_escape(16'hFFFF);
                    default: add_u_escape(16'($urandom_range(16'hDFFF, 16'hDC00)));
                endcase
            end
        endcase
    endfunction

    function automatic void add_well_formed();
        append_char(CH_QUOTE);
        repeat ($urandom_range(6)) add_element();
        append_char(CH_QUOTE);
        if ($urandom_range(4) == 0) begin
            repeat ($urandom_range(2, 1)) append_char(8'($urandom_range(255)));
        end
    endfunction

    // Mostly clean strings; the rest cut short, corrupted, bad escapes or noise
    task automatic random_text();
        int unsigned pick;
        int unsigned keep;
        pick = $urandom_range(99);
        if (pick < 70) begin
            add_well_formed();
        end else if (pick < 84) begin
            add_well_formed();
            if ($urandom_range(1)) begin
                keep = $urandom_range(text_q.size() - 1, 1);
                while (text_q.size() > keep) void'(text_q.pop_back());
            end else begin
                text_q[$urandom_range(text_q.size() - 1)] = 8'($urandom_range(255));
            end
        end else if (pick < 93) begin
            append_char(CH_QUOTE);
            repeat ($urandom_range(2)) add_element();
            append_char(CH_BSL);
            if ($urandom_range(1)) begin
                append_char(8'($urandom_range(255)));
            end else begin
                append_char(CH_U);
                repeat ($urandom_range(3)) append_char(hex_ascii(4'($urandom_range(15))));
                append_char(8'($urandom_range(255)));
            end
            if ($urandom_range(1)) append_char(CH_QUOTE);
        end else begin
            if ($urandom_range(1)) append_char(CH_QUOTE);
            repeat ($urandom_range(6, 1)) append_char(8'($urandom_range(255)));
        end
        send_text();
    endtask

    initial begin
        int goal;

        // Hold reset, then release it on a falling edge
        repeat (6) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        src_idle_pct  = 20;
        sink_idle_pct = 86;

        // No opening quote, on the top byte value
        append_char(8'hFF);
        send_text();
        // Zero byte, lone high surrogate broken by a bad escape, then a dropped byte
        append_char(CH_QUOTE);
        append_char(8'h00);
        add_chars("\\uDBfF\\xA");
        send_text();
        // Non-hex byte inside a \u group
        add_chars("\"\\ug");
        send_text();
        // Lone surrogate followed by a plain byte, close, byte after close dropped
        add_chars("\"\\ud800A\"z");
        send_text();
        // Text ends right after a backslash
        add_chars("\"\\");
        send_text();
        // Text ends inside the low half of a pair
        add_chars("\"\\uD83D\\u1");
        send_text();
        // Text ends with a \u group and no digits
        add_chars("\"\\u");
        send_text();

        // Random part in three idling regimes
        goal = board.total_bytes;
        for (int p = 0; p < 3; p++) begin
            case (p)
                0: begin
                    src_idle_pct  = 20;
                    sink_idle_pct = 86;
                end
                1: begin
                    src_idle_pct  = 86;
                    sink_idle_pct = 20;
                end
                default: begin
                    src_idle_pct  = 0;
                    sink_idle_pct = 0;
                end
            endcase
            goal += 70;
            while (board.total_bytes < goal) random_text();
        end

        @(negedge aclk);
        s_tvalid = 1'b0;
        s_tlast  = 1'b0;

        // Drain, then give the block time to show any stray transfer
        while (board.awaited.size() != 0) @(posedge aclk);
        repeat (20) @(posedge aclk);

        $display("covered %0d texts, %0d bytes sent (%0d decoded), %0d results checked",
                 texts_sent, board.total_bytes, board.live_bytes, board.seen_results);
        $display("strings closed: %0d, error markers: %0d, mismatches: %0d",
                 board.closes, board.faults, board.mismatches);
        if (board.mismatches == 0 && board.awaited.size() == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

    // Watchdog: far beyond the slowest legal run
    initial begin
        #2000000;
        $display("timeout with %0d results outstanding", board.awaited.size());
        $display("RESULT: ERROR");
        $finish;
    end

endmodule

/* filelist.f */
sv/jsu_pkg.sv
sv/jsu_decode.sv
sv/jsu_outq.sv
sv/json_string_unescape_utf8.sv
test/json_string_unescape_utf8_test.sv
